### hw/rtl/hcd_pkg.sv
`timescale 1ns / 1ps

package hcd_pkg;

  // fixed field widths
  localparam int IDX_W  = 8;
  localparam int SYM_W  = 8;
  localparam int KEY_W  = 32;
  localparam int CNT_W  = 6;
  localparam int MODE_W = 2;
  localparam int STAT_W = 2;

  // defaults for the top level parameters
  localparam int DEF_ENTRIES      = 256;
  localparam int DEF_MAX_CODE_LEN = 32;

  // codebook slots per first-level priority group
  localparam int GROUP_SIZE = 16;

  typedef enum logic [MODE_W-1:0] {
    MODE_LOAD   = 2'd0,
    MODE_DECODE = 2'd1,
    MODE_END    = 2'd2
  } mode_e;

  typedef enum logic [STAT_W-1:0] {
    ST_OK       = 2'd0,
    ST_DISCARD  = 2'd1,
    ST_OVERFLOW = 2'd2
  } status_e;

  // one input transaction as held in the input register
  typedef struct packed {
    logic [MODE_W-1:0] mode;
    logic [IDX_W-1:0]  idx;
    logic [SYM_W-1:0]  sym;
    logic [KEY_W-1:0]  code;
    logic [CNT_W-1:0]  len;
    logic              bit_in;
  } item_t;

  // per-transaction result fields that do not depend on the symbol select
  typedef struct packed {
    logic              sym_valid;
    status_e           status;
    logic [CNT_W-1:0]  pending;
  } res_t;

  // mask of the low n bits, n up to KEY_W
  function automatic logic [KEY_W-1:0] len_mask(logic [CNT_W-1:0] n);
    logic [KEY_W:0] m;
    m = (KEY_W + 1)'(1) << n;
    m = m - (KEY_W + 1)'(1);
    return m[KEY_W-1:0];
  endfunction

endpackage

### hw/rtl/hcd_match.sv
`timescale 1ns / 1ps

module hcd_match import hcd_pkg::*; #(
  parameter int ENTRIES      = DEF_ENTRIES,
  parameter int MAX_CODE_LEN = DEF_MAX_CODE_LEN,
  localparam int NumGroups   = (ENTRIES + GROUP_SIZE - 1) / GROUP_SIZE
) (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  logic                              in_valid_i,
  output logic                              in_ready_o,
  input  item_t                             in_item_i,
  output logic                              out_valid_o,
  input  logic                              out_ready_i,
  output res_t                              out_res_o,
  output logic [NumGroups-1:0]              out_grp_hit_o,
  output logic [NumGroups-1:0][SYM_W-1:0]   out_grp_sym_o
);

  localparam int KeyLimit  = (MAX_CODE_LEN < KEY_W) ? MAX_CODE_LEN : KEY_W;
  localparam int IdxW      = $clog2(ENTRIES);
  localparam int PadSlots  = NumGroups * GROUP_SIZE;
  localparam logic [IDX_W:0] EntriesLim = (IDX_W + 1)'(ENTRIES);

  // codebook cells and key state
  logic [KEY_W-1:0] code_q [ENTRIES];
  logic [CNT_W-1:0] len_q  [ENTRIES];
  logic [SYM_W-1:0] sym_q  [ENTRIES];
  logic [KEY_W-1:0] key_q, key_d, key_shift, key_mask;
  logic [CNT_W-1:0] cnt_q, cnt_d, cnt_inc;

  logic [PadSlots-1:0]              hit;
  logic [SYM_W-1:0]                 sym_pad [PadSlots];
  logic                             any_hit, is_decode, load_en, advance;
  logic [IdxW-1:0]                  widx;
  res_t                             res_d, res_q;
  logic [NumGroups-1:0]             ghit_d, ghit_q;
  logic [NumGroups-1:0][SYM_W-1:0]  gsym_d, gsym_q;
  logic                             valid_q;

  assign in_ready_o = !valid_q || out_ready_i;
  assign advance    = in_valid_i && in_ready_o;
  assign is_decode  = (in_item_i.mode == MODE_DECODE);
  assign widx       = in_item_i.idx[IdxW-1:0];

  // key after shifting in the new bit
  assign key_shift = {key_q[KEY_W-2:0], in_item_i.bit_in};
  assign cnt_inc   = cnt_q + CNT_W'(1);
  assign key_mask  = len_mask(cnt_inc);

  // every used slot compares against the grown key; pad slots never hit
  for (genvar i = 0; i < PadSlots; i++) begin : g_slot
    if (i < ENTRIES) begin : g_used
      assign hit[i] = is_decode && (len_q[i] == cnt_inc) &&
                      (((code_q[i] ^ key_shift) & key_mask) == '0);
      assign sym_pad[i] = sym_q[i];
    end else begin : g_pad
      assign hit[i]     = 1'b0;
      assign sym_pad[i] = '0;
    end
  end

  assign any_hit = |hit;

  // lowest matching slot inside each group
  always_comb begin
    for (int g = 0; g < NumGroups; g++) begin
      ghit_d[g] = |hit[g*GROUP_SIZE +: GROUP_SIZE];
      gsym_d[g] = '0;
      for (int j = GROUP_SIZE - 1; j >= 0; j--) begin
        if (hit[g*GROUP_SIZE + j]) begin
          gsym_d[g] = sym_pad[g*GROUP_SIZE + j];
        end
      end
    end
  end

  // key update and result fields
  always_comb begin
    key_d            = key_q;
    cnt_d            = cnt_q;
    load_en          = 1'b0;
    res_d.sym_valid  = 1'b0;
    res_d.status     = ST_OK;
    case (mode_e'(in_item_i.mode))
      MODE_LOAD: begin
        load_en = ({1'b0, in_item_i.idx} < EntriesLim);
      end
      MODE_DECODE: begin
        if (any_hit) begin
          key_d           = '0;
          cnt_d           = '0;
          res_d.sym_valid = 1'b1;
        end else if (cnt_inc >= CNT_W'(KeyLimit)) begin
          key_d        = '0;
          cnt_d        = '0;
          res_d.status = ST_OVERFLOW;
        end else begin
          key_d = key_shift;
          cnt_d = cnt_inc;
        end
      end
      MODE_END: begin
        if (cnt_q != '0) begin
          res_d.status = ST_DISCARD;
        end
        key_d = '0;
        cnt_d = '0;
      end
      default: begin
      end
    endcase
    res_d.pending = cnt_d;
  end

  // control state and slot lengths
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      key_q   <= '0;
      cnt_q   <= '0;
      valid_q <= 1'b0;
      for (int i = 0; i < ENTRIES; i++) begin
        len_q[i] <= '0;
      end
    end else begin
      if (in_ready_o) begin
        valid_q <= in_valid_i;
      end
      if (advance) begin
        key_q <= key_d;
        cnt_q <= cnt_d;
        if (load_en) begin
          len_q[widx] <= in_item_i.len;
        end
      end
    end
  end

  // codebook payload and stage output
  always_ff @(posedge clk_i) begin
    if (advance) begin
      res_q  <= res_d;
      ghit_q <= ghit_d;
      gsym_q <= gsym_d;
      if (load_en) begin
        code_q[widx] <= in_item_i.code;
        sym_q[widx]  <= in_item_i.sym;
      end
    end
  end

  assign out_valid_o   = valid_q;
  assign out_res_o     = res_q;
  assign out_grp_hit_o = ghit_q;
  assign out_grp_sym_o = gsym_q;

  // key never grows past its limit
  a_cnt_limit: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cnt_q <= CNT_W'(KeyLimit))
    else $error("key count beyond limit");

  // key bits above the count stay clear
  a_key_clean: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (key_q & ~len_mask(cnt_q)) == '0)
    else $error("stale bits above key count");

endmodule

### hw/rtl/hcd_select.sv
`timescale 1ns / 1ps

module hcd_select import hcd_pkg::*; #(
  parameter int ENTRIES    = DEF_ENTRIES,
  localparam int NumGroups = (ENTRIES + GROUP_SIZE - 1) / GROUP_SIZE
) (
  input  logic                             clk_i,
  input  logic                             rst_ni,
  input  logic                             in_valid_i,
  output logic                             in_ready_o,
  input  res_t                             in_res_i,
  input  logic [NumGroups-1:0]             in_grp_hit_i,
  input  logic [NumGroups-1:0][SYM_W-1:0]  in_grp_sym_i,
  output logic                             out_valid_o,
  input  logic                             out_ready_i,
  output res_t                             out_res_o,
  output logic [SYM_W-1:0]                 out_symbol_o
);

  logic             valid_q;
  res_t             res_q;
  logic [SYM_W-1:0] sym_d, sym_q;

  assign in_ready_o = !valid_q || out_ready_i;

  // lowest matching group wins
  always_comb begin
    sym_d = '0;
    for (int g = NumGroups - 1; g >= 0; g--) begin
      if (in_grp_hit_i[g]) begin
        sym_d = in_grp_sym_i[g];
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (in_ready_o) begin
      valid_q <= in_valid_i;
    end
  end

  // result register
  always_ff @(posedge clk_i) begin
    if (in_valid_i && in_ready_o) begin
      res_q <= in_res_i;
      sym_q <= sym_d;
    end
  end

  assign out_valid_o  = valid_q;
  assign out_res_o    = res_q;
  assign out_symbol_o = sym_q;

  // a completed code word leaves an empty key and no error
  a_hit_clean: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (valid_q && res_q.sym_valid) |-> (res_q.status == ST_OK && res_q.pending == '0))
    else $error("symbol with error status or pending bits");

  // no symbol value without a match
  a_sym_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (valid_q && !res_q.sym_valid) |-> (sym_q == '0))
    else $error("symbol set without a match");

endmodule

### hw/rtl/huffman_codebook_decoder.sv
`timescale 1ns / 1ps

// Bit-serial prefix-code decoder with a loadable codebook.
// Input channel (in_valid_i / in_ready_o): mode_i selects a load of one
// codebook slot (entry_index_i, entry_symbol_i, entry_code_i, entry_length_i),
// a decode of one coded bit (bit_in_i) or an end of message.
// Output channel (out_valid_o / out_ready_i): exactly one result per input
// transaction, in order: symbol_valid_o, symbol_o, status_o, pending_bits_o.
// A result passes three registers after its input transaction is
// taken (input register, then slot compare, then group priority select).
// Throughput: one transaction per cycle unless the receiver stalls; the key
// update, the loop, compares all slots in parallel against the grown key.
// A load is seen by the very next decode transaction.
// When the receiver stalls, the three registers fill and in_ready_o falls;
// nothing is dropped. Reset clears the key, all slot lengths (every slot
// unused) and the pipeline; the block takes transactions right after it.

module huffman_codebook_decoder import hcd_pkg::*; #(
  parameter int ENTRIES      = DEF_ENTRIES,
  parameter int MAX_CODE_LEN = DEF_MAX_CODE_LEN
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              in_valid_i,
  output logic              in_ready_o,
  input  logic [MODE_W-1:0] mode_i,
  input  logic [IDX_W-1:0]  entry_index_i,
  input  logic [SYM_W-1:0]  entry_symbol_i,
  input  logic [KEY_W-1:0]  entry_code_i,
  input  logic [CNT_W-1:0]  entry_length_i,
  input  logic              bit_in_i,
  output logic              out_valid_o,
  input  logic              out_ready_i,
  output logic              symbol_valid_o,
  output logic [SYM_W-1:0]  symbol_o,
  output logic [STAT_W-1:0] status_o,
  output logic [CNT_W-1:0]  pending_bits_o
);

  localparam int NumGroups = (ENTRIES + GROUP_SIZE - 1) / GROUP_SIZE;

  logic                             a_valid_q;
  item_t                            a_item_q;
  logic                             m_ready, m_valid, s_ready;
  res_t                             m_res, s_res;
  logic [NumGroups-1:0]             m_grp_hit;
  logic [NumGroups-1:0][SYM_W-1:0]  m_grp_sym;

  assign in_ready_o = !a_valid_q || m_ready;

  // input register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      a_valid_q <= 1'b0;
    end else if (in_ready_o) begin
      a_valid_q <= in_valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_valid_i && in_ready_o) begin
      a_item_q.mode   <= mode_i;
      a_item_q.idx    <= entry_index_i;
      a_item_q.sym    <= entry_symbol_i;
      a_item_q.code   <= entry_code_i;
      a_item_q.len    <= entry_length_i;
      a_item_q.bit_in <= bit_in_i;
    end
  end

  hcd_match #(
    .ENTRIES      (ENTRIES),
    .MAX_CODE_LEN (MAX_CODE_LEN)
  ) u_match (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .in_valid_i    (a_valid_q),
    .in_ready_o    (m_ready),
    .in_item_i     (a_item_q),
    .out_valid_o   (m_valid),
    .out_ready_i   (s_ready),
    .out_res_o     (m_res),
    .out_grp_hit_o (m_grp_hit),
    .out_grp_sym_o (m_grp_sym)
  );

  hcd_select #(
    .ENTRIES (ENTRIES)
  ) u_select (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .in_valid_i   (m_valid),
    .in_ready_o   (s_ready),
    .in_res_i     (m_res),
    .in_grp_hit_i (m_grp_hit),
    .in_grp_sym_i (m_grp_sym),
    .out_valid_o  (out_valid_o),
    .out_ready_i  (out_ready_i),
    .out_res_o    (s_res),
    .out_symbol_o (symbol_o)
  );

  assign symbol_valid_o = s_res.sym_valid;
  assign status_o       = s_res.status;
  assign pending_bits_o = s_res.pending;

endmodule
